### hdl/psel_pkg.sv
// ----------------------------------------------------------------------------
// psel_pkg
// Shared codes and the command and status bundles of the patch slot selector.
// ----------------------------------------------------------------------------
`default_nettype none

package psel_pkg;

  localparam int SLOTS_DEF = 32;

  // configuration register index
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE_ALL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE_CUR = 1'b1;

  localparam logic [6:0] ERASE_ALL_RST = 7'd127;
  localparam logic [6:0] ERASE_CUR_RST = 7'd1;

  // item functions
  localparam logic [2:0] FUNC_SWITCH = 3'd0;
  localparam logic [2:0] FUNC_SAVE   = 3'd1;
  localparam logic [2:0] FUNC_COPY   = 3'd2;
  localparam logic [2:0] FUNC_ERASE  = 3'd3;
  localparam logic [2:0] FUNC_LOAD   = 3'd4;

  // reported actions
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_LOAD    = 3'd1;
  localparam logic [2:0] ACT_DEFAULT = 3'd2;
  localparam logic [2:0] ACT_EMPTY   = 3'd3;
  localparam logic [2:0] ACT_PROMPT  = 3'd4;
  localparam logic [2:0] ACT_SHOW    = 3'd5;
  localparam logic [2:0] ACT_NOFREE  = 3'd6;
  localparam logic [2:0] ACT_SAVED   = 3'd7;

  typedef struct packed {
    logic       latch;
    logic       search_start;
    logic       search_free;
    logic       search_up;
    logic       search_step;
    logic       set_pending;
    logic       prompt;
    logic       move;
    logic       confirm;
    logic       cancel;
    logic       save;
    logic       erase_all;
    logic       erase_cur;
    logic       load_entry;
    logic       rd_cur;
    logic       copy_wr;
    logic       rd_rep;
    logic       out_load;
    logic [2:0] act;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       conflict;
    logic       down;
    logic       awaiting;
    logic       dirty;
    logic       ev_all;
    logic       ev_cur;
    logic       search_done;
    logic       search_hit;
  } status_t;

endpackage

`default_nettype wire

### hdl/patch_slot_selector_core.sv
// ----------------------------------------------------------------------------
// patch_slot_selector_core
// Patch slot table with wraparound slot search, save prompt and table edits.
// ----------------------------------------------------------------------------
// usage:
//   an item word is taken at a clock edge with start high and busy low; busy
//   stays high until the result goes out. each item gives one result word,
//   shown for one cycle with done high; the receiver cannot stall it.
//   configuration writes use cfg_valid/cfg_ready (ready is always high),
//   cfg_index 0 sets the erase-all code and 1 the erase-current code; write
//   them only while busy is low.
// sequence:
//   after the accepting edge an item passes the decode state, the slot walk
//   for switch, copy and erase-current items (one slot per cycle through the
//   walker), the table read and write of a copy, then the table read and the
//   output state before done rises. busy falls with done, so a new item can be
//   taken in the done cycle.
// reset:
//   synchronous rst clears all slots (per-slot valid bits, no clearing pass),
//   current and pending slot, the confirm flag and the header flag, and loads
//   the erase codes with 127 and 1.
// ----------------------------------------------------------------------------
`default_nettype none

module patch_slot_selector_core #(
  parameter int SLOTS = psel_pkg::SLOTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [2:0]                     func,
  input  wire logic                           down_edge,
  input  wire logic                           up_edge,
  input  wire logic                           dirty,
  input  wire logic [6:0]                     erase_value,
  input  wire logic [7:0]                     msg_count,
  input  wire logic [15:0]                    patch_sum,
  input  wire logic [4:0]                     slot_index,
  input  wire logic                           header_ok,
  output logic                                done,
  output logic [2:0]                          action,
  output logic [4:0]                          patch_number,
  output logic [7:0]                          slot_count,
  output logic [15:0]                         slot_sum,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [psel_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [6:0]                     cfg_data
);
  import psel_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  psel_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  psel_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .func         (func),
    .down_edge    (down_edge),
    .up_edge      (up_edge),
    .dirty        (dirty),
    .erase_value  (erase_value),
    .msg_count    (msg_count),
    .patch_sum    (patch_sum),
    .slot_index   (slot_index),
    .header_ok    (header_ok),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .action       (action),
    .patch_number (patch_number),
    .slot_count   (slot_count),
    .slot_sum     (slot_sum)
  );

endmodule

`default_nettype wire

### hdl/psel_datapath.sv
// ----------------------------------------------------------------------------
// psel_datapath
// Slot table, current/pending slot registers, slot walker and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module psel_datapath #(
  parameter int SLOTS = psel_pkg::SLOTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire psel_pkg::cmd_t                 cmd,
  output psel_pkg::status_t                   status,
  input  wire logic [2:0]                     func,
  input  wire logic                           down_edge,
  input  wire logic                           up_edge,
  input  wire logic                           dirty,
  input  wire logic [6:0]                     erase_value,
  input  wire logic [7:0]                     msg_count,
  input  wire logic [15:0]                    patch_sum,
  input  wire logic [4:0]                     slot_index,
  input  wire logic                           header_ok,
  input  wire logic                           cfg_we,
  input  wire logic [psel_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [6:0]                     cfg_data,
  output logic                                done,
  output logic [2:0]                          action,
  output logic [4:0]                          patch_number,
  output logic [7:0]                          slot_count,
  output logic [15:0]                         slot_sum
);
  import psel_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

  // latched item
  logic [2:0]  func_q;
  logic        down_q;
  logic        up_q;
  logic        dirty_q;
  logic [6:0]  ev_q;
  logic [7:0]  cnt_q;
  logic [15:0] sum_q;
  logic [4:0]  idx_q;
  logic        hok_q;

  logic [6:0]  erase_all_code;
  logic [6:0]  erase_cur_code;

  logic [SW-1:0]    cur;
  logic [SW-1:0]    pending;
  logic             awaiting;
  logic             hv;
  logic [SLOTS-1:0] valid;
  logic [SLOTS-1:0] occ;

  logic [SW-1:0] walker;
  logic          search_up_q;
  logic          search_free_q;
  logic          match;

  logic [23:0]   mem [SLOTS];
  logic [23:0]   rd_data;
  logic          rd_valid;
  logic          rd_en;
  logic [SW-1:0] rd_addr;
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  logic [23:0]   wr_data;
  logic [23:0]   eff_data;

  logic [SW-1:0] rep;
  logic [SW-1:0] rep_q;
  logic [2:0]    act_q;
  logic [2:0]    load_act;

  logic [SW+4:0] idx_ext;
  logic [SW-1:0] idx_w;
  logic          load_ok;
  logic [SW+4:0] rep_ext;

  function automatic logic [SW-1:0] step_slot(input logic [SW-1:0] n, input logic up);
    logic [SW-1:0] r;
    if (up) begin
      r = (n == LAST) ? '0 : n + SW'(1);
    end else begin
      r = (n == '0) ? LAST : n - SW'(1);
    end
    return r;
  endfunction

  assign idx_ext = {{SW{1'b0}}, idx_q};
  assign idx_w   = idx_ext[SW-1:0];
  assign load_ok = hok_q && ({27'd0, idx_q} < 32'(SLOTS));

  assign match = search_free_q ? !occ[walker] : occ[walker];

  assign status.func        = func_q;
  assign status.conflict    = (down_q == up_q);
  assign status.down        = down_q;
  assign status.awaiting    = awaiting;
  assign status.dirty       = dirty_q;
  assign status.ev_all      = (ev_q == erase_all_code);
  assign status.ev_cur      = (ev_q == erase_cur_code);
  assign status.search_done = (walker == cur) || match;
  assign status.search_hit  = (walker != cur) && match;

  assign rep      = (cmd.act == ACT_PROMPT) ? pending : cur;
  assign load_act = !hv ? ACT_DEFAULT : (occ[rep] ? ACT_LOAD : ACT_EMPTY);
  assign eff_data = rd_valid ? rd_data : 24'd0;

  // table port selection
  always_comb begin
    rd_en   = cmd.rd_cur || cmd.rd_rep;
    rd_addr = cmd.rd_rep ? rep : cur;
    wr_en   = 1'b0;
    wr_addr = cur;
    wr_data = {cnt_q, sum_q};
    if (cmd.save) begin
      wr_en = 1'b1;
    end else if (cmd.load_entry && load_ok) begin
      wr_en   = 1'b1;
      wr_addr = idx_w;
    end else if (cmd.copy_wr) begin
      wr_en   = 1'b1;
      wr_addr = walker;
      wr_data = eff_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data  <= mem[rd_addr];
      rd_valid <= valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_q  <= func;
      down_q  <= down_edge;
      up_q    <= up_edge;
      dirty_q <= dirty;
      ev_q    <= erase_value;
      cnt_q   <= msg_count;
      sum_q   <= patch_sum;
      idx_q   <= slot_index;
      hok_q   <= header_ok;
    end
    if (cmd.search_start) begin
      walker        <= step_slot(cur, cmd.search_up);
      search_up_q   <= cmd.search_up;
      search_free_q <= cmd.search_free;
    end else if (cmd.search_step) begin
      walker <= step_slot(walker, search_up_q);
    end
    if (cmd.rd_rep) begin
      rep_q <= rep;
      act_q <= (cmd.act == ACT_LOAD) ? load_act : cmd.act;
    end
    if (cmd.out_load) begin
      action       <= act_q;
      patch_number <= rep_ext[4:0];
      slot_count   <= eff_data[23:16];
      slot_sum     <= eff_data[15:0];
    end
  end

  assign rep_ext = {5'd0, rep_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      erase_all_code <= ERASE_ALL_RST;
      erase_cur_code <= ERASE_CUR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ERASE_ALL: erase_all_code <= cfg_data;
        CFG_ERASE_CUR: erase_cur_code <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur      <= '0;
      pending  <= '0;
      awaiting <= 1'b0;
      hv       <= 1'b0;
      valid    <= '0;
      occ      <= '0;
      done     <= 1'b0;
    end else begin
      done <= cmd.out_load;
      if (cmd.erase_all) begin
        valid <= '0;
        occ   <= '0;
        hv    <= 1'b0;
        cur   <= '0;
      end else if (cmd.erase_cur) begin
        valid[cur] <= 1'b0;
        occ[cur]   <= 1'b0;
        hv         <= 1'b1;
      end else if (cmd.save) begin
        valid[cur] <= 1'b1;
        occ[cur]   <= (cnt_q != 8'd0);
        hv         <= 1'b1;
      end else if (cmd.load_entry && load_ok) begin
        valid[idx_w] <= 1'b1;
        occ[idx_w]   <= (cnt_q != 8'd0);
        hv           <= 1'b1;
      end else if (cmd.copy_wr) begin
        valid[walker] <= 1'b1;
        occ[walker]   <= (eff_data[23:16] != 8'd0);
        cur           <= walker;
      end
      if (cmd.set_pending) begin
        pending <= walker;
      end
      if (cmd.prompt) begin
        awaiting <= 1'b1;
      end
      if (cmd.move) begin
        cur <= walker;
      end
      if (cmd.confirm) begin
        cur      <= pending;
        awaiting <= 1'b0;
      end
      if (cmd.cancel) begin
        awaiting <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/psel_ctrl.sv
// ----------------------------------------------------------------------------
// psel_ctrl
// Sequencer: decodes an item, runs the slot walk, copy, table read and result.
// ----------------------------------------------------------------------------
`default_nettype none

module psel_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire psel_pkg::status_t status,
  output psel_pkg::cmd_t         cmd
);
  import psel_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_SEARCH  = 3'd2;
  localparam logic [2:0] S_COPY_RD = 3'd3;
  localparam logic [2:0] S_COPY_WR = 3'd4;
  localparam logic [2:0] S_READ    = 3'd5;
  localparam logic [2:0] S_OUT     = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] act;
  logic [2:0] act_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    act_next   = act;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_READ;
        act_next   = ACT_NONE;
        case (status.func)
          FUNC_SWITCH: begin
            if (status.conflict) begin
              act_next = ACT_NONE;
            end else if (!status.awaiting) begin
              cmd.search_start = 1'b1;
              cmd.search_up    = !status.down;
              state_next       = S_SEARCH;
            end else if (status.down) begin
              cmd.confirm = 1'b1;
              act_next    = ACT_LOAD;
            end else begin
              cmd.cancel = 1'b1;
              act_next   = ACT_SHOW;
            end
          end
          FUNC_SAVE: begin
            cmd.save = 1'b1;
            act_next = ACT_SAVED;
          end
          FUNC_COPY: begin
            cmd.search_start = 1'b1;
            cmd.search_free  = 1'b1;
            cmd.search_up    = 1'b1;
            state_next       = S_SEARCH;
          end
          FUNC_ERASE: begin
            if (status.ev_all) begin
              cmd.erase_all = 1'b1;
              act_next      = ACT_LOAD;
            end else if (status.ev_cur) begin
              // walk starts beside the slot being cleared
              cmd.erase_cur    = 1'b1;
              cmd.search_start = 1'b1;
              state_next       = S_SEARCH;
            end
          end
          FUNC_LOAD: begin
            cmd.load_entry = 1'b1;
          end
          default: ;
        endcase
      end
      S_SEARCH: begin
        if (!status.search_done) begin
          cmd.search_step = 1'b1;
        end else begin
          state_next = S_READ;
          case (status.func)
            FUNC_SWITCH: begin
              if (status.search_hit) begin
                cmd.set_pending = 1'b1;
                if (status.dirty) begin
                  cmd.prompt = 1'b1;
                  act_next   = ACT_PROMPT;
                end else begin
                  cmd.move = 1'b1;
                  act_next = ACT_LOAD;
                end
              end else begin
                act_next = ACT_NONE;
              end
            end
            FUNC_COPY: begin
              if (status.search_hit) begin
                state_next = S_COPY_RD;
              end else begin
                act_next = ACT_NOFREE;
              end
            end
            default: begin
              cmd.move = status.search_hit;
              act_next = ACT_LOAD;
            end
          endcase
        end
      end
      S_COPY_RD: begin
        cmd.rd_cur = 1'b1;
        state_next = S_COPY_WR;
      end
      S_COPY_WR: begin
        cmd.copy_wr = 1'b1;
        act_next    = ACT_SHOW;
        state_next  = S_READ;
      end
      S_READ: begin
        cmd.rd_rep = 1'b1;
        cmd.act    = act;
        state_next = S_OUT;
      end
      S_OUT: begin
        cmd.out_load = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      act   <= ACT_NONE;
    end else begin
      state <= state_next;
      act   <= act_next;
    end
  end

  a_search_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH && status.search_done) |=> (state != S_SEARCH))
    else $error("slot walk did not stop when done");

  a_search_entry: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> ($past(state) == S_DECODE || $past(state) == S_SEARCH))
    else $error("slot walk entered from wrong state");

  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && state == S_IDLE) |=> (state == S_DECODE && $past(cmd.latch)))
    else $error("accepted word not latched");

  a_out_once: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> (state == S_IDLE && !cmd.out_load))
    else $error("result issued twice");

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the patch slot selector core: short directed runs
// over slot moves, the save prompt, copy, erase and table loads, then random
// phases under several erase code settings with random sender gaps. Every
// result word is checked field by field against a local slot table model.
// ----------------------------------------------------------------------------

module tb;
  import psel_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  localparam int PHASE_ITEMS = 315;

  typedef struct packed {
    logic [2:0]  func;
    logic        down;
    logic        up;
    logic        dirty;
    logic [6:0]  ev;
    logic [7:0]  cnt;
    logic [15:0] sum;
    logic [4:0]  idx;
    logic        hok;
  } item_t;

  typedef struct packed {
    logic [2:0]  act;
    logic [4:0]  num;
    logic [7:0]  cnt;
    logic [15:0] sum;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] func = '0;
  logic down_edge = 1'b0;
  logic up_edge = 1'b0;
  logic dirty = 1'b0;
  logic [6:0] erase_value = '0;
  logic [7:0] msg_count = '0;
  logic [15:0] patch_sum = '0;
  logic [4:0] slot_index = '0;
  logic header_ok = 1'b0;
  logic done;
  logic [2:0] action;
  logic [4:0] patch_number;
  logic [7:0] slot_count;
  logic [15:0] slot_sum;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;

  // slot table model
  logic [7:0] cnt_tbl [SLOTS];
  logic [15:0] sum_tbl [SLOTS];
  logic [4:0] cur_slot;
  logic [4:0] pend_slot;
  logic confirm_wait;
  logic hdr_valid;
  logic [6:0] code_all;
  logic [6:0] code_cur;

  report_t slot_reports_q [$];
  report_t want_rep;
  int fail_cnt = 0;
  int gap_max = 19;

  patch_slot_selector_core #(.SLOTS(SLOTS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .func(func), .down_edge(down_edge), .up_edge(up_edge), .dirty(dirty),
    .erase_value(erase_value), .msg_count(msg_count), .patch_sum(patch_sum),
    .slot_index(slot_index), .header_ok(header_ok),
    .done(done), .action(action), .patch_number(patch_number),
    .slot_count(slot_count), .slot_sum(slot_sum),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void table_reset();
    for (int i = 0; i < SLOTS; i++) begin
      cnt_tbl[i] = '0;
      sum_tbl[i] = '0;
    end
    cur_slot = '0;
    pend_slot = '0;
    confirm_wait = 1'b0;
    hdr_valid = 1'b0;
    code_all = ERASE_ALL_RST;
    code_cur = ERASE_CUR_RST;
  endfunction

  function automatic int adjacent_slot(int n, bit up);
    if (up) return (n + 1 >= SLOTS) ? 0 : n + 1;
    return (n == 0) ? SLOTS - 1 : n - 1;
  endfunction

  // walks with wraparound, gives back the origin when nothing else is used
  function automatic int next_used(int from, bit up);
    int n;
    n = adjacent_slot(from, up);
    while (cnt_tbl[n] == 0) begin
      n = adjacent_slot(n, up);
      if (n == from) break;
    end
    return n;
  endfunction

  function automatic int next_free(int from);
    int n;
    n = adjacent_slot(from, 1'b1);
    while (n != from && cnt_tbl[n] != 0) n = adjacent_slot(n, 1'b1);
    return n;
  endfunction

  function automatic logic [2:0] load_result(int n);
    if (!hdr_valid) return ACT_DEFAULT;
    return (cnt_tbl[n] == 0) ? ACT_EMPTY : ACT_LOAD;
  endfunction

  function automatic report_t slot_report(logic [2:0] act, int n);
    report_t r;
    r.act = act;
    r.num = n[4:0];
    r.cnt = cnt_tbl[n];
    r.sum = sum_tbl[n];
    return r;
  endfunction

  function automatic report_t selector_step(item_t it);
    logic [2:0] act;
    int n;
    act = ACT_NONE;
    case (it.func)
      FUNC_SWITCH: begin
        if (it.down != it.up) begin
          if (!confirm_wait) begin
            n = next_used(int'(cur_slot), it.up);
            if (n != int'(cur_slot)) begin
              pend_slot = n[4:0];
              if (it.dirty) begin
                confirm_wait = 1'b1;
                return slot_report(ACT_PROMPT, int'(pend_slot));
              end
              cur_slot = n[4:0];
              act = load_result(int'(cur_slot));
            end
          end else if (it.down) begin
            cur_slot = pend_slot;
            confirm_wait = 1'b0;
            act = load_result(int'(cur_slot));
          end else begin
            confirm_wait = 1'b0;
            act = ACT_SHOW;
          end
        end
      end
      FUNC_SAVE: begin
        cnt_tbl[cur_slot] = it.cnt;
        sum_tbl[cur_slot] = it.sum;
        hdr_valid = 1'b1;
        act = ACT_SAVED;
      end
      FUNC_COPY: begin
        n = next_free(int'(cur_slot));
        if (n == int'(cur_slot)) begin
          act = ACT_NOFREE;
        end else begin
          cnt_tbl[n] = cnt_tbl[cur_slot];
          sum_tbl[n] = sum_tbl[cur_slot];
          cur_slot = n[4:0];
          act = ACT_SHOW;
        end
      end
      FUNC_ERASE: begin
        if (it.ev == code_all) begin
          for (int i = 0; i < SLOTS; i++) begin
            cnt_tbl[i] = '0;
            sum_tbl[i] = '0;
          end
          hdr_valid = 1'b0;
          cur_slot = '0;
          act = load_result(int'(cur_slot));
        end else if (it.ev == code_cur) begin
          cnt_tbl[cur_slot] = '0;
          sum_tbl[cur_slot] = '0;
          cur_slot = 5'(next_used(int'(cur_slot), 1'b0));
          hdr_valid = 1'b1;
          act = load_result(int'(cur_slot));
        end
      end
      FUNC_LOAD: begin
        if (it.hok && it.idx < SLOTS) begin
          cnt_tbl[it.idx] = it.cnt;
          sum_tbl[it.idx] = it.sum;
          hdr_valid = 1'b1;
        end
      end
      default: ;
    endcase
    return slot_report(act, int'(cur_slot));
  endfunction

  function automatic item_t quiet_item(logic [2:0] f);
    item_t it;
    it = '0;
    it.func = f;
    return it;
  endfunction

  function automatic item_t switch_item(bit down, bit up, bit dirty_flag);
    item_t it;
    it = quiet_item(FUNC_SWITCH);
    it.down = down;
    it.up = up;
    it.dirty = dirty_flag;
    return it;
  endfunction

  function automatic item_t entry_item(logic [2:0] f, int idx, int cnt, int sum, bit hok);
    item_t it;
    it = quiet_item(f);
    it.idx = idx[4:0];
    it.cnt = cnt[7:0];
    it.sum = sum[15:0];
    it.hok = hok;
    return it;
  endfunction

  function automatic item_t erase_item(logic [6:0] ev);
    item_t it;
    it = quiet_item(FUNC_ERASE);
    it.ev = ev;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int pick;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      it.func = FUNC_SWITCH;
      if ($urandom_range(0, 99) < 85) begin
        it.up = 1'($urandom_range(0, 1));
        it.down = ~it.up;
      end
      it.dirty = ($urandom_range(0, 99) < 35);
    end else if (pick < 52) begin
      it.func = FUNC_SAVE;
    end else if (pick < 60) begin
      it.func = FUNC_COPY;
    end else if (pick < 70) begin
      it.func = FUNC_ERASE;
      pick = $urandom_range(0, 99);
      if (pick < 6) it.ev = code_all;
      else if (pick < 40) it.ev = code_cur;
    end else if (pick < 94) begin
      it.func = FUNC_LOAD;
      it.hok = ($urandom_range(0, 99) < 85);
    end else begin
      it.func = FUNC_LOAD + 3'($urandom_range(1, 3));
    end
    if ($urandom_range(0, 4) == 0) it.cnt = '0;
    return it;
  endfunction

  // one item word over start/busy, model updated at the accepting edge
  task automatic send_item(item_t it);
    int gap;
    gap = $urandom_range(0, gap_max);
    func <= it.func;
    down_edge <= it.down;
    up_edge <= it.up;
    dirty <= it.dirty;
    erase_value <= it.ev;
    msg_count <= it.cnt;
    patch_sum <= it.sum;
    slot_index <= it.idx;
    header_ok <= it.hok;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    slot_reports_q.push_back(selector_step(it));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (slot_reports_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [6:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_ERASE_ALL) code_all = data;
    else code_cur = data;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      fail_cnt++;
      if (fail_cnt <= 40)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (slot_reports_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 40)
          $display("%0t: unexpected result word, expected none, actual action %0d slot %0d",
                   $time, action, patch_number);
      end else begin
        want_rep = slot_reports_q.pop_front();
        check_field("action", 16'(want_rep.act), 16'(action));
        check_field("patch_number", 16'(want_rep.num), 16'(patch_number));
        check_field("slot_count", 16'(want_rep.cnt), 16'(slot_count));
        check_field("slot_sum", want_rep.sum, slot_sum);
      end
    end
  end

  // empty table: no move possible, both or neither switch is a no-op
  task automatic test_empty_switch();
    send_item(switch_item(1'b0, 1'b1, 1'b0));
    send_item(switch_item(1'b1, 1'b0, 1'b1));
    send_item(switch_item(1'b1, 1'b1, 1'b0));
    send_item(switch_item(1'b0, 1'b0, 1'b1));
  endtask

  task automatic test_unknown_func();
    for (int k = 1; k <= 3; k++) send_item(quiet_item(FUNC_LOAD + 3'(k)));
  endtask

  task automatic test_save_and_move();
    send_item(entry_item(FUNC_SAVE, 0, 255, 65535, 1'b0));
    send_item(entry_item(FUNC_LOAD, 31, 1, 0, 1'b1));
    send_item(entry_item(FUNC_LOAD, 5, 200, 1234, 1'b0));
    send_item(switch_item(1'b1, 1'b0, 1'b0));
    send_item(switch_item(1'b0, 1'b1, 1'b0));
  endtask

  // dirty move prompts, up cancels, down confirms
  task automatic test_save_prompt();
    send_item(switch_item(1'b0, 1'b1, 1'b1));
    send_item(switch_item(1'b0, 1'b1, 1'b0));
    send_item(switch_item(1'b1, 1'b0, 1'b1));
    send_item(switch_item(1'b1, 1'b0, 1'b0));
  endtask

  task automatic test_copy();
    send_item(quiet_item(FUNC_COPY));
  endtask

  task automatic test_erase();
    send_item(erase_item(7'd64));
    send_item(erase_item(ERASE_CUR_RST));
    send_item(erase_item(ERASE_ALL_RST));
    send_item(erase_item(ERASE_CUR_RST));
  endtask

  // fill every slot, then copy finds no free slot
  task automatic test_table_full();
    for (int i = 0; i < SLOTS; i++)
      send_item(entry_item(FUNC_LOAD, i, $urandom_range(1, 255), $urandom, 1'b1));
    send_item(quiet_item(FUNC_COPY));
    send_item(switch_item(1'b1, 1'b0, 1'b0));
    send_item(quiet_item(FUNC_COPY));
  endtask

  task automatic test_random_mix();
    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          cfg_write(CFG_ERASE_ALL, 7'd0);
          cfg_write(CFG_ERASE_CUR, 7'd127);
        end
        1: begin
          // equal codes: erase-all wins
          cfg_write(CFG_ERASE_ALL, 7'd127);
          cfg_write(CFG_ERASE_CUR, 7'd127);
        end
        2: begin
          cfg_write(CFG_ERASE_ALL, 7'd127);
          cfg_write(CFG_ERASE_CUR, 7'd0);
        end
        5: begin
          cfg_write(CFG_ERASE_ALL, ERASE_ALL_RST);
          cfg_write(CFG_ERASE_CUR, ERASE_CUR_RST);
        end
        default: begin
          cfg_write(CFG_ERASE_ALL, 7'($urandom));
          cfg_write(CFG_ERASE_CUR, 7'($urandom));
        end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 40 == 0) begin
          case ($urandom_range(0, 2))
            0: gap_max = 0;
            1: gap_max = 4;
            default: gap_max = 19;
          endcase
        end
        if ($urandom_range(0, 99) == 0) wait_idle();
        send_item(random_item());
      end
    end
  endtask

  initial begin
    table_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_switch();
    test_unknown_func();
    test_save_and_move();
    test_save_prompt();
    test_copy();
    test_erase();
    test_table_full();
    test_random_mix();
    wait_idle();
    repeat (SLOTS + 10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[patch_slot_selector_core] OK");
    end else begin
      $display("[patch_slot_selector_core] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[patch_slot_selector_core] ERROR");
    $finish;
  end

endmodule
